### rtl/core/bmd_pkg.sv
// Shared types, codes and the CRC-16 byte step for the battery reply deframer.
`timescale 1ns / 1ps
`default_nettype none
package bmd_pkg;

   // Input operation codes.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_ABORT = 2'd2;

   // Query kinds.
   localparam logic [1:0] Q_NONE  = 2'd0;
   localparam logic [1:0] Q_CELLS = 2'd1;
   localparam logic [1:0] Q_STATE = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_CELL    = 3'd0;
   localparam logic [2:0] KIND_PACK    = 3'd1;
   localparam logic [2:0] KIND_CRC     = 3'd2;
   localparam logic [2:0] KIND_REJECT  = 3'd3;
   localparam logic [2:0] KIND_NODEC   = 3'd4;

   // Configuration register indexes.
   localparam logic [7:0] CSR_DEVICE_ADDRESS = 8'd0;
   localparam logic [7:0] CSR_READ_FUNCTION  = 8'd1;

   // Register indexes used by a pack state reply.
   localparam logic [3:0] REG_PACK_MV   = 4'd0;
   localparam logic [3:0] REG_CURRENT   = 4'd1;
   localparam logic [3:0] REG_SOC       = 4'd2;
   localparam logic [3:0] REG_TEMP_A    = 4'd5;
   localparam logic [3:0] REG_TEMP_B    = 4'd6;
   localparam logic [3:0] REG_CHARGER   = 4'd11;
   localparam logic [3:0] REG_LOAD      = 4'd12;
   localparam logic [3:0] REG_CHG_SW    = 4'd13;
   localparam logic [3:0] REG_DIS_SW    = 4'd14;

   // Frame constants.
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
   localparam logic [8:0]  EXC_LEN        = 9'd5;
   localparam int          EXC_BIT        = 7;
   localparam logic [6:0]  STATE_REGS     = 7'd16;
   localparam logic [6:0]  PACK_SCALE     = 7'd100;
   localparam logic [15:0] CURRENT_OFFSET = 16'd30000;
   localparam logic [15:0] TEMP_OFFSET    = 16'd80;
   localparam int          MAX_CELLS_OUT  = 16;

   // Register word store: sixteen 16-bit registers after the header.
   localparam int WORD_DEPTH = 16;
   localparam int WORD_AW    = 4;

   typedef enum logic [1:0] {
      JOB_STATUS,
      JOB_CELLS,
      JOB_STATE
   } job_kind_type;

   // One finished frame handed from the front to the back.
   typedef struct packed {
      job_kind_type job;
      logic [2:0]   kind;
   } job_type;

   typedef struct packed {
      logic                en;
      logic [WORD_AW-1:0]  addr;
      logic [15:0]         data;
   } ram_wr_type;

   typedef struct packed {
      logic reading;
      logic mem_done;
   } back_stat_type;

   // One byte of CRC-16/MODBUS, reflected polynomial.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/core/bms_modbus_reply_deframer.sv
// Top level of the Modbus RTU read reply deframer for a battery monitor.
//
// The req channel carries one item per event: a start or abort of a query
// (tuser selects the operation) or one received byte. Bytes are framed on the
// device address, checked with CRC-16/MODBUS, and the rsp channel returns one
// item per cell, one pack state item, or one status item per frame; tlast
// marks the final item of a frame. The csr channel writes the device address
// (index 0) or the read function code (index 1), and only while idle.
// The third byte of a valid header starts a pass that folds the three header
// bytes into the CRC, one byte per cycle. A status item is put in the job
// queue at the closing byte and then loaded into the output register. A cells
// reply is read from the register word RAM one cell at a time (address, then
// registered data); a pack state reply sweeps fifteen words the same way
// and emits one item after that. Bytes are held off while such a frame is
// being read out; start and abort events are still taken, and status frames
// wait in the two-entry job queue. If the receiver stalls, the output register
// holds its item and the back stops; the front keeps taking items until the
// queue fills.
// Reset clears the framing state, the pending query and the registers to
// their defaults; the word RAM needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module bms_modbus_reply_deframer
   import bmd_pkg::*;
#(
   parameter int CELL_COUNT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,  // operation
   input  wire logic [15:0] req_tdata,  // query_kind, rx_byte, zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,  // kind
   output logic [87:0]      rsp_tdata,  // cell_index, cell_mv, pack_mv, current_x10a,
                                        // soc_x10pct, temp_x10c, charger_seen, load_seen,
                                        // charge_switch_on, discharge_switch_on
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   job_type            push_job, pop_job;
   logic               job_push, job_pop, fifo_full, fifo_not_empty;
   ram_wr_type         ram_wr;
   back_stat_type      back_stat;
   logic [WORD_AW-1:0] ram_rd_addr;
   logic [15:0]        ram_rd_data;
   logic [3:0]         cell_index;
   logic [15:0]        cell_mv, pack_mv, current, soc, temp;
   logic [3:0]         flags;

   bmd_front #(.CELL_COUNT(CELL_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .job_push   (job_push),
      .job_data   (push_job),
      .fifo_full  (fifo_full),
      .back_stat  (back_stat),
      .ram_wr     (ram_wr)
   );

   bmd_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .not_empty (fifo_not_empty),
      .full      (fifo_full)
   );

   bmd_ram #(.WIDTH(16), .DEPTH(WORD_DEPTH)) u_words (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bmd_back #(.CELL_COUNT(CELL_COUNT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (fifo_not_empty),
      .job_data       (pop_job),
      .job_pop        (job_pop),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .back_stat      (back_stat),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_kind       (rsp_tuser),
      .rsp_cell_index (cell_index),
      .rsp_cell_mv    (cell_mv),
      .rsp_pack_mv    (pack_mv),
      .rsp_current    (current),
      .rsp_soc        (soc),
      .rsp_temp       (temp),
      .rsp_flags      (flags),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {flags, temp, soc, current, pack_mv, cell_mv, cell_index};

   // The word RAM is never written while the back is reading it.
   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> !back_stat.reading)
      else $error("word RAM written while the back reads it");

   // A finished frame always finds room in the job queue.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !fifo_full)
      else $error("job pushed into a full queue");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

### rtl/core/bmd_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/core/bmd_job_fifo.sv
// Two-entry queue of finished frame jobs between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module bmd_job_fifo
   import bmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   input  wire logic    pop,
   output job_type      pop_data,
   output logic         not_empty,
   output logic         full
);

   job_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign not_empty = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);
   assign pop_data  = mem_ff[rptr_ff];

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

endmodule
`default_nettype wire

### rtl/core/bmd_front.sv
// Front part: takes events and bytes, frames replies, checks CRC and queues a job.
`timescale 1ns / 1ps
`default_nettype none
module bmd_front
   import bmd_pkg::*;
#(
   parameter int CELL_COUNT = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [1:0]    req_tuser,
   input  wire logic [15:0]   req_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_index,
   input  wire logic [7:0]    csr_data,
   output logic               job_push,
   output job_type            job_data,
   input  wire logic          fifo_full,
   input  wire back_stat_type back_stat,
   output ram_wr_type         ram_wr
);

   localparam logic [6:0] CELLS_NEEDED = 7'(CELL_COUNT);

   typedef enum logic {
      F_IDLE,
      F_HCRC
   } fstate_type;

   fstate_type  fstate_ff, fstate_in;
   logic [1:0]  hstep_ff, hstep_in;
   logic [8:0]  count_ff, count_in;
   logic [8:0]  expected_ff, expected_in;
   logic [7:0]  b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in, prev_ff, prev_in;
   logic [15:0] crc_ff, crc_in;
   logic [1:0]  pend_ff, pend_in;
   logic [7:0]  dev_ff, dev_in, func_ff, func_in;
   logic        mem_busy_ff, mem_busy_in;

   logic [1:0]  op, qk;
   logic [7:0]  rxb, hbyte;
   logic [15:0] crc_step;
   logic [8:0]  offset;
   logic [6:0]  regs;
   logic        req_fire, csr_fire;

   assign op  = req_tuser;
   assign qk  = req_tdata[1:0];
   assign rxb = req_tdata[9:2];

   assign csr_ready  = (fstate_ff == F_IDLE);
   assign req_tready = (fstate_ff == F_IDLE) && !csr_valid &&
                       ((op != OP_BYTE) || (!fifo_full && !mem_busy_ff));
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   assign crc_step = crc_byte(crc_ff, rxb);
   assign offset   = count_ff - 9'd3;
   assign regs     = b2_ff[7:1];

   // Header byte fed to the CRC while a new frame header is folded in.
   always_comb begin
      case (hstep_ff)
         2'd0:    hbyte = b0_ff;
         2'd1:    hbyte = b1_ff;
         default: hbyte = b2_ff;
      endcase
   end

   // Register words are written once both bytes of a pair have arrived.
   always_comb begin
      ram_wr.en   = req_fire && (op == OP_BYTE) && (count_ff >= 9'd3) &&
                    (offset < 9'(2 * WORD_DEPTH)) && offset[0];
      ram_wr.addr = offset[WORD_AW:1];
      ram_wr.data = {prev_ff, rxb};
   end

   // Framing and next-state logic.
   always_comb begin
      fstate_in   = fstate_ff;
      hstep_in    = hstep_ff;
      count_in    = count_ff;
      expected_in = expected_ff;
      b0_in       = b0_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      prev_in     = prev_ff;
      crc_in      = crc_ff;
      pend_in     = pend_ff;
      dev_in      = dev_ff;
      func_in     = func_ff;
      mem_busy_in = mem_busy_ff;
      job_push    = 1'b0;
      job_data    = '{job: JOB_STATUS, kind: KIND_NODEC};

      if (back_stat.mem_done) begin
         mem_busy_in = 1'b0;
      end

      if (fstate_ff == F_HCRC) begin
         crc_in   = crc_byte(crc_ff, hbyte);
         hstep_in = hstep_ff + 2'd1;
         if (hstep_ff == 2'd2) begin
            fstate_in = F_IDLE;
         end
      end else if (csr_fire) begin
         if (csr_index == CSR_DEVICE_ADDRESS) begin
            dev_in   = csr_data;
            count_in = '0;
            crc_in   = CRC_INIT;
         end else if (csr_index == CSR_READ_FUNCTION) begin
            func_in  = csr_data;
            count_in = '0;
            crc_in   = CRC_INIT;
         end
      end else if (req_fire) begin
         case (op)
            OP_START: begin
               pend_in  = (qk == Q_CELLS || qk == Q_STATE) ? qk : Q_NONE;
               count_in = '0;
               crc_in   = CRC_INIT;
            end
            OP_ABORT: begin
               pend_in  = Q_NONE;
               count_in = '0;
               crc_in   = CRC_INIT;
            end
            OP_BYTE: begin
               if (count_ff == 9'd0) begin
                  b0_in    = rxb;
                  count_in = 9'd1;
               end else if (count_ff == 9'd1) begin
                  b1_in    = rxb;
                  count_in = 9'd2;
               end else if (count_ff == 9'd2) begin
                  // Three bytes held: strip to the address, then check the header.
                  if (b0_ff == dev_ff) begin
                     if (b1_ff == func_ff || b1_ff[EXC_BIT]) begin
                        b2_in       = rxb;
                        count_in    = 9'd3;
                        expected_in = (b1_ff == func_ff) ? FRAME_OVERHEAD + {1'b0, rxb}
                                                         : EXC_LEN;
                        crc_in      = CRC_INIT;
                        hstep_in    = 2'd0;
                        fstate_in   = F_HCRC;
                     end else begin
                        b0_in    = b1_ff;
                        b1_in    = rxb;
                        count_in = 9'd2;
                     end
                  end else if (b1_ff == dev_ff) begin
                     b0_in    = b1_ff;
                     b1_in    = rxb;
                     count_in = 9'd2;
                  end else if (rxb == dev_ff) begin
                     b0_in    = rxb;
                     count_in = 9'd1;
                  end else begin
                     count_in = 9'd0;
                  end
               end else begin
                  // Frame body: fold into the CRC and close the frame at its length.
                  crc_in  = crc_step;
                  prev_in = rxb;
                  if (count_ff + 9'd1 == expected_ff) begin
                     job_push = 1'b1;
                     pend_in  = Q_NONE;
                     count_in = '0;
                     crc_in   = CRC_INIT;
                     if (crc_step != 16'd0) begin
                        job_data.kind = KIND_CRC;
                     end else if (b1_ff != func_ff) begin
                        job_data.kind = KIND_REJECT;
                     end else if (pend_ff == Q_CELLS && regs >= CELLS_NEEDED) begin
                        job_data.job = JOB_CELLS;
                        job_data.kind = KIND_CELL;
                        mem_busy_in  = 1'b1;
                     end else if (pend_ff == Q_STATE && regs >= STATE_REGS) begin
                        job_data.job = JOB_STATE;
                        job_data.kind = KIND_PACK;
                        mem_busy_in  = 1'b1;
                     end
                  end else begin
                     count_in = count_ff + 9'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff   <= F_IDLE;
         hstep_ff    <= 2'd0;
         count_ff    <= '0;
         crc_ff      <= CRC_INIT;
         pend_ff     <= Q_NONE;
         dev_ff      <= 8'd210;
         func_ff     <= 8'd3;
         mem_busy_ff <= 1'b0;
      end else begin
         fstate_ff   <= fstate_in;
         hstep_ff    <= hstep_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         pend_ff     <= pend_in;
         dev_ff      <= dev_in;
         func_ff     <= func_in;
         mem_busy_ff <= mem_busy_in;
      end
   end

   // Header bytes and frame length.
   always_ff @(posedge clock) begin
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      prev_ff     <= prev_in;
      expected_ff <= expected_in;
   end

endmodule
`default_nettype wire

### rtl/core/bmd_back.sv
// Back part: turns queued frame jobs into result items, reading register words.
`timescale 1ns / 1ps
`default_nettype none
module bmd_back
   import bmd_pkg::*;
#(
   parameter int CELL_COUNT = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                job_valid,
   input  wire job_type             job_data,
   output logic                     job_pop,
   output logic [WORD_AW-1:0]       ram_rd_addr,
   input  wire logic [15:0]         ram_rd_data,
   output back_stat_type            back_stat,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [2:0]               rsp_kind,
   output logic [3:0]               rsp_cell_index,
   output logic [15:0]              rsp_cell_mv,
   output logic [15:0]              rsp_pack_mv,
   output logic [15:0]              rsp_current,
   output logic [15:0]              rsp_soc,
   output logic [15:0]              rsp_temp,
   output logic [3:0]               rsp_flags,
   output logic                     rsp_last
);

   localparam int         N_EMIT    = (CELL_COUNT > MAX_CELLS_OUT) ? MAX_CELLS_OUT : CELL_COUNT;
   localparam logic [3:0] LAST_CELL = 4'(N_EMIT - 1);

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_LOAD,
      B_EMIT
   } bstate_type;

   bstate_type   bstate_ff;
   job_kind_type jobk_ff;
   logic [3:0]   idx_ff;
   logic [15:0]  r0_ff, r1_ff, r2_ff, r5_ff, r6_ff;
   logic [3:0]   flags_ff;
   logic         out_free;
   logic         emit;
   logic [22:0]  pack_prod;
   logic [15:0]  temp_sum, temp_val, current_val;

   assign out_free    = !rsp_tvalid || rsp_tready;
   assign ram_rd_addr = idx_ff;

   assign job_pop = (bstate_ff == B_IDLE) && job_valid &&
                    ((job_data.job != JOB_STATUS) || out_free);

   // An item is loaded into the output register in this cycle.
   assign emit = out_free &&
                 (((bstate_ff == B_IDLE) && job_valid && (job_data.job == JOB_STATUS)) ||
                  ((bstate_ff == B_LOAD) && (jobk_ff == JOB_CELLS)) ||
                  (bstate_ff == B_EMIT));

   assign back_stat.reading  = (bstate_ff != B_IDLE);
   assign back_stat.mem_done = out_free &&
                               (((bstate_ff == B_LOAD) && (jobk_ff == JOB_CELLS) &&
                                 (idx_ff == LAST_CELL)) || (bstate_ff == B_EMIT));

   // Pack state scaling.
   assign pack_prod   = r0_ff * PACK_SCALE;
   assign current_val = r1_ff - CURRENT_OFFSET;
   assign temp_sum    = r5_ff + r6_ff - TEMP_OFFSET;
   assign temp_val    = (temp_sum << 2) + temp_sum;

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff  <= B_IDLE;
         rsp_tvalid <= 1'b0;
      end else begin
         if (emit) begin
            rsp_tvalid <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
         unique case (bstate_ff)
            B_IDLE: begin
               if (job_valid) begin
                  if (job_data.job == JOB_STATUS) begin
                     if (out_free) begin
                        rsp_kind       <= job_data.kind;
                        rsp_cell_index <= '0;
                        rsp_cell_mv    <= '0;
                        rsp_pack_mv    <= '0;
                        rsp_current    <= '0;
                        rsp_soc        <= '0;
                        rsp_temp       <= '0;
                        rsp_flags      <= '0;
                        rsp_last       <= 1'b1;
                     end
                  end else begin
                     jobk_ff   <= job_data.job;
                     idx_ff    <= '0;
                     flags_ff  <= '0;
                     bstate_ff <= B_READ;
                  end
               end
            end
            B_READ: begin
               bstate_ff <= B_LOAD;
            end
            B_LOAD: begin
               if (jobk_ff == JOB_CELLS) begin
                  if (out_free) begin
                     rsp_kind       <= KIND_CELL;
                     rsp_cell_index <= idx_ff;
                     rsp_cell_mv    <= ram_rd_data;
                     rsp_pack_mv    <= '0;
                     rsp_current    <= '0;
                     rsp_soc        <= '0;
                     rsp_temp       <= '0;
                     rsp_flags      <= '0;
                     rsp_last       <= (idx_ff == LAST_CELL);
                     if (idx_ff == LAST_CELL) begin
                        bstate_ff <= B_IDLE;
                     end else begin
                        idx_ff    <= idx_ff + 4'd1;
                        bstate_ff <= B_READ;
                     end
                  end
               end else begin
                  case (idx_ff)
                     REG_PACK_MV: r0_ff <= ram_rd_data;
                     REG_CURRENT: r1_ff <= ram_rd_data;
                     REG_SOC:     r2_ff <= ram_rd_data;
                     REG_TEMP_A:  r5_ff <= ram_rd_data;
                     REG_TEMP_B:  r6_ff <= ram_rd_data;
                     REG_CHARGER: flags_ff[0] <= (ram_rd_data != 16'd0);
                     REG_LOAD:    flags_ff[1] <= (ram_rd_data != 16'd0);
                     REG_CHG_SW:  flags_ff[2] <= (ram_rd_data != 16'd0);
                     REG_DIS_SW:  flags_ff[3] <= (ram_rd_data != 16'd0);
                     default: begin
                     end
                  endcase
                  if (idx_ff == REG_DIS_SW) begin
                     bstate_ff <= B_EMIT;
                  end else begin
                     idx_ff    <= idx_ff + 4'd1;
                     bstate_ff <= B_READ;
                  end
               end
            end
            B_EMIT: begin
               if (out_free) begin
                  rsp_kind       <= KIND_PACK;
                  rsp_cell_index <= '0;
                  rsp_cell_mv    <= '0;
                  rsp_pack_mv    <= pack_prod[15:0];
                  rsp_current    <= current_val;
                  rsp_soc        <= r2_ff;
                  rsp_temp       <= temp_val;
                  rsp_flags      <= flags_ff;
                  rsp_last       <= 1'b1;
                  bstate_ff      <= B_IDLE;
               end
            end
            default: bstate_ff <= B_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
